@@ rtl/isort_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// isort_pkg
// Shared types and constants of the indexed integer sorter.
// ----------------------------------------------------------------------------
package isort_pkg;

	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} isort_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // input transaction in the load phase
		logic start;    // last item accepted: freeze base, open the first scan
		logic scan_rd;  // issue one store read
		logic emit;     // result transaction: advance to the next rank
		logic run_end;  // final result taken: empty the store
	} isort_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last; // read address is the last filled slot
		logic run_last;  // the pending result is the final one of the run
	} isort_stat_t;

endpackage : isort_pkg
`default_nettype wire

@@ rtl/isort_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// isort_in_if
// Input channel of the sorter: one vector element per transaction.
// ----------------------------------------------------------------------------
interface isort_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value_in;
	logic               last_in;

	modport source (output valid, output value_in, output last_in, input ready);
	modport sink (input valid, input value_in, input last_in, output ready);
endinterface : isort_in_if
`default_nettype wire

@@ rtl/isort_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// isort_out_if
// Result channel of the sorter: one sorted element per transaction.
// ----------------------------------------------------------------------------
interface isort_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value_out;
	logic signed [31:0] original_index;
	logic               last_out;
	logic               overflow;

	modport source (output valid, output value_out, output original_index,
		output last_out, output overflow, input ready);
	modport sink (input valid, input value_out, input original_index,
		input last_out, input overflow, output ready);
endinterface : isort_out_if
`default_nettype wire

@@ rtl/isort_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// isort_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module isort_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule : isort_ram
`default_nettype wire

@@ rtl/isort_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// isort_ctrl
// Sequencer of the sorter: load, scan for the next rank, emit.
// ----------------------------------------------------------------------------
module isort_ctrl
	import isort_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	input  wire logic        item_last,
	output logic             item_ready,
	output logic             result_valid,
	input  wire logic        result_ready,
	input  wire isort_stat_t stat,
	output isort_cmd_t       cmd
);

	isort_state_t state_q, state_d;
	logic         item_fire, result_fire;

	assign item_ready   = (state_q == ST_LOAD);
	assign result_valid = (state_q == ST_EMIT);
	assign item_fire    = item_valid && item_ready;
	assign result_fire  = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (item_fire && item_last) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.scan_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (result_fire) state_d = stat.run_last ? ST_LOAD : ST_SCAN;
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.load    = item_fire;
		cmd.start   = item_fire && item_last;
		cmd.scan_rd = (state_q == ST_SCAN);
		cmd.emit    = result_fire;
		cmd.run_end = result_fire && stat.run_last;
	end

endmodule : isort_ctrl
`default_nettype wire

@@ rtl/isort_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// isort_dp
// Datapath of the sorter: element store, minimum search, result registers.
// Each scan finds the smallest (value, slot) pair above the one emitted last.
// ----------------------------------------------------------------------------
module isort_dp
	import isort_pkg::*;
#(
	parameter int MAX_ITEMS = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire isort_cmd_t         cmd,
	output isort_stat_t             stat,
	input  wire logic               cfg_wr_en,
	input  wire logic signed [31:0] cfg_wr_data,
	input  wire logic signed [31:0] value_in,
	output logic signed      [31:0] value_out,
	output logic signed      [31:0] original_index,
	output logic                    last_out,
	output logic                    overflow
);

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam logic [CW-1:0] CAP = CW'(MAX_ITEMS);

	logic signed [31:0] base_q, run_base_q;
	logic [CW-1:0]      count_q, emitted_q, last_slot;
	logic               dropped_q;
	logic [AW-1:0]      rd_addr_q;
	logic               rd_vld_s1;
	logic [AW-1:0]      rd_pos_s1;
	logic signed [31:0] rd_data;
	logic signed [31:0] best_val_q, prev_val_q;
	logic [AW-1:0]      best_pos_q, prev_pos_q;
	logic               best_vld_q, prev_vld_q;
	logic               above_prev, below_best;

	isort_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_ITEMS),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (cmd.load && (count_q < CAP)),
		.waddr(count_q[AW-1:0]),
		.wdata(value_in),
		.raddr(rd_addr_q),
		.rdata(rd_data)
	);

	assign last_slot      = count_q - CW'(1);
	assign stat.scan_last = ({{(CW-AW){1'b0}}, rd_addr_q} == last_slot);
	assign stat.run_last  = (emitted_q == last_slot);

	// ordering on (value, slot): slots are unique, so the order is strict
	assign above_prev = !prev_vld_q || (rd_data > prev_val_q) ||
		((rd_data == prev_val_q) && (rd_pos_s1 > prev_pos_q));
	assign below_best = !best_vld_q || (rd_data < best_val_q) ||
		((rd_data == best_val_q) && (rd_pos_s1 < best_pos_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= 32'sd1;
			count_q    <= '0;
			dropped_q  <= 1'b0;
			emitted_q  <= '0;
			rd_addr_q  <= '0;
			rd_vld_s1  <= 1'b0;
			best_vld_q <= 1'b0;
			prev_vld_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				base_q <= cfg_wr_data;
			end
			if (cmd.load) begin
				if (count_q < CAP) begin
					count_q <= count_q + CW'(1);
				end else begin
					dropped_q <= 1'b1;
				end
			end
			rd_vld_s1 <= cmd.scan_rd;
			if (cmd.scan_rd) begin
				rd_addr_q <= rd_addr_q + AW'(1);
			end
			if (rd_vld_s1 && above_prev && below_best) begin
				best_vld_q <= 1'b1;
			end
			if (cmd.start) begin
				rd_addr_q  <= '0;
				emitted_q  <= '0;
				best_vld_q <= 1'b0;
				prev_vld_q <= 1'b0;
			end
			if (cmd.emit) begin
				rd_addr_q  <= '0;
				emitted_q  <= emitted_q + CW'(1);
				best_vld_q <= 1'b0;
				prev_vld_q <= 1'b1;
			end
			if (cmd.run_end) begin
				count_q   <= '0;
				dropped_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_pos_s1 <= rd_addr_q;
		if (cmd.start) begin
			run_base_q <= base_q;
		end
		if (rd_vld_s1 && above_prev && below_best) begin
			best_val_q <= rd_data;
			best_pos_q <= rd_pos_s1;
		end
		if (cmd.emit) begin
			prev_val_q <= best_val_q;
			prev_pos_q <= best_pos_q;
		end
	end

	assign value_out      = best_val_q;
	assign original_index = run_base_q + $signed({{(32-AW){1'b0}}, best_pos_q});
	assign last_out       = stat.run_last;
	assign overflow       = dropped_q;

endmodule : isort_dp
`default_nettype wire

@@ rtl/integer_sort_with_index.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// integer_sort_with_index
// Argsort of a vector of signed 32-bit integers, ties by arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   item   : one element per transaction (value_in, last_in). Elements are
//            taken one per cycle during load; those beyond MAX_ITEMS are
//            dropped and every result of that run carries overflow.
//   result : after the element marked last, all stored elements come out in
//            ascending order with original_index = base_index + arrival
//            position; last_out marks the final one.
//   cfg    : cfg_wr_en / cfg_wr_data write base_index (reset value 1); the
//            value held when the last element arrives is used for the run.
// Operation: each result takes one scan of the single-read store by the minimum
//   search and a final compare, then the result is offered and held through
//   receiver stalls; no element is taken until the run is drained.
// Reset clears the store count, the drop flag and the sequencer; a held
//   result waits in its registers for as long as the receiver stalls.
// ----------------------------------------------------------------------------
module integer_sort_with_index
	import isort_pkg::*;
#(
	parameter int MAX_ITEMS = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic signed [31:0] cfg_wr_data,
	isort_in_if.sink                item,
	isort_out_if.source             result
);

	isort_cmd_t  cmd;
	isort_stat_t stat;

	isort_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.item_last   (item.last_in),
		.item_ready  (item.ready),
		.result_valid(result.valid),
		.result_ready(result.ready),
		.stat        (stat),
		.cmd         (cmd)
	);

	isort_dp #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.value_in      (item.value_in),
		.value_out     (result.value_out),
		.original_index(result.original_index),
		.last_out      (result.last_out),
		.overflow      (result.overflow)
	);

endmodule : integer_sort_with_index
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for integer_sort_with_index. Directed runs cover the
// value extremes, ties, index wrap, a base change in the middle of a run,
// capacity overflow and a long output stall. Random runs of varying length
// follow under several idle and stall mixes. Every result is compared with an
// argsort computed in the bench at the time the last element is taken.
// ----------------------------------------------------------------------------
module tb;
	import isort_pkg::*;

	localparam int MAX_ITEMS     = 64;
	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 6;
	localparam int LIMIT_CYCLES  = 500_000;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 200;
	localparam int PHASE_ITEMS   = 34;

	typedef logic signed [DATA_W-1:0] word_t;

	localparam word_t WORD_MIN = 32'h8000_0000;
	localparam word_t WORD_MAX = 32'h7fff_ffff;

	typedef struct {
		word_t value;
		word_t index;
		logic  last;
		logic  overflow;
	} ranked_t;

	logic  clk;
	logic  arst_n;
	logic  cfg_wr_en;
	word_t cfg_wr_data;

	isort_in_if  item_ch ();
	isort_out_if result_ch ();

	integer_sort_with_index #(.MAX_ITEMS(MAX_ITEMS)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.item       (item_ch),
		.result     (result_ch)
	);

	// bench copy of the block's state
	word_t   base_shadow;
	word_t   held_value [MAX_ITEMS];
	int      held_count;
	bit      held_dropped;
	ranked_t ranked_q [$];

	int mismatch_count;
	int src_idle_pct;
	int sink_stall_pct;
	int hold_left;
	int cycle_count;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Store one element; on the last one, rank everything held (stable on
	// arrival order) and queue the expected results.
	function automatic void load_element(input word_t v, input logic l);
		int      order [MAX_ITEMS];
		int      s;
		int      j;
		ranked_t r;
		if (held_count >= MAX_ITEMS) begin
			held_dropped = 1'b1;
		end else begin
			held_value[held_count] = v;
			held_count++;
		end
		if (l) begin
			for (int i = 0; i < held_count; i++) begin
				s = i;
				j = i;
				while (j > 0 && held_value[s] < held_value[order[j-1]]) begin
					order[j] = order[j-1];
					j--;
				end
				order[j] = s;
			end
			for (int i = 0; i < held_count; i++) begin
				r.value    = held_value[order[i]];
				r.index    = base_shadow + word_t'(order[i]);
				r.last     = (i == held_count - 1);
				r.overflow = held_dropped;
				ranked_q.push_back(r);
			end
			held_count   = 0;
			held_dropped = 1'b0;
		end
	endfunction

	function automatic word_t pick_value();
		case ($urandom_range(3))
			0: return word_t'($urandom_range(8)) - 4;
			1: begin
				case ($urandom_range(4))
					0: return WORD_MIN;
					1: return WORD_MAX;
					2: return word_t'(-1);
					3: return word_t'(0);
					default: return word_t'(1);
				endcase
			end
			default: return word_t'($urandom());
		endcase
	endfunction

	function automatic word_t pick_base();
		case ($urandom_range(7))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return WORD_MAX - 5;
			3: return word_t'(-1);
			4: return word_t'(0);
			default: return word_t'($urandom());
		endcase
	endfunction

	task automatic check_field(input string name, input word_t want, input word_t got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// result monitor
	always @(posedge clk) begin : check_result
		ranked_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (ranked_q.size() == 0) begin
				$error("value_out: expected no result, got %0d", result_ch.value_out);
				mismatch_count++;
			end else begin
				want = ranked_q.pop_front();
				check_field("value_out", want.value, result_ch.value_out);
				check_field("original_index", want.index, result_ch.original_index);
				check_field("last_out", word_t'(want.last), word_t'(result_ch.last_out));
				check_field("overflow", word_t'(want.overflow), word_t'(result_ch.overflow));
			end
		end
	end

	// receiver: random stalls, or a counted hold-off when one is armed
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	task automatic send_element(input word_t v, input logic l);
		forever begin
			@(negedge clk);
			if ($urandom_range(99) >= src_idle_pct)
				break;
			item_ch.valid <= 1'b0;
		end
		item_ch.valid    <= 1'b1;
		item_ch.value_in <= v;
		item_ch.last_in  <= l;
		do @(posedge clk); while (!item_ch.ready);
		load_element(v, l);
	endtask

	task automatic send_run(input int n);
		for (int i = 0; i < n; i++)
			send_element(pick_value(), i == n - 1);
	endtask

	task automatic write_base(input word_t v);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		base_shadow = v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// drop valid, wait for every queued result, then let the block settle
	task automatic wait_drained();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (ranked_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_extreme_values();
		// single element under the reset base
		send_element(WORD_MIN, 1'b1);
		send_element(WORD_MAX, 1'b0);
		send_element(WORD_MIN, 1'b0);
		send_element(word_t'(0), 1'b0);
		send_element(word_t'(-1), 1'b0);
		send_element(word_t'(1), 1'b1);
		wait_drained();
	endtask

	task automatic test_ties_and_wrap();
		// indexes cross the top of the signed range
		write_base(WORD_MAX - 1);
		send_element(word_t'(5), 1'b0);
		send_element(word_t'(-3), 1'b0);
		send_element(word_t'(5), 1'b0);
		send_element(word_t'(5), 1'b0);
		send_element(word_t'(-3), 1'b0);
		send_element(WORD_MIN, 1'b1);
		wait_drained();
	endtask

	task automatic test_base_mid_run();
		write_base(word_t'(-1));
		send_element(word_t'(7), 1'b0);
		send_element(word_t'(7), 1'b0);
		send_element(word_t'(-7), 1'b0);
		wait_drained();
		// the base in force at the last element applies to the whole run
		write_base(WORD_MIN);
		send_element(word_t'(0), 1'b0);
		send_element(word_t'(7), 1'b1);
		wait_drained();
		write_base(word_t'(0));
		send_element(word_t'(42), 1'b1);
		wait_drained();
	endtask

	task automatic test_capacity();
		// two past capacity: the last element itself is dropped
		send_run(MAX_ITEMS + 2);
		wait_drained();
		send_run(MAX_ITEMS);
		wait_drained();
		send_run(2);
		wait_drained();
	endtask

	task automatic test_backpressure();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		@(posedge clk);
		hold_left = 600;
		// second run stalls at the input until the first one drains
		send_run(8);
		send_run(8);
		wait_drained();
	endtask

	task automatic run_random_phase(input int src_pct, input int sink_pct);
		int sent;
		int n;
		int r;
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		write_base(pick_base());
		sent = 0;
		while (sent < PHASE_ITEMS) begin
			r = $urandom_range(99);
			if (r < 70)
				n = $urandom_range(8, 1);
			else if (r < 95)
				n = $urandom_range(24, 9);
			else
				n = $urandom_range(MAX_ITEMS, 25);
			send_run(n);
			sent += n;
			if ($urandom_range(3) == 0) begin
				wait_drained();
				write_base(pick_base());
			end
		end
		wait_drained();
	endtask

	task automatic test_random_traffic();
		run_random_phase(0, 0);
		run_random_phase(69, 0);
		run_random_phase(0, 69);
		run_random_phase(20, 20);
	endtask

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: errors");
		$finish;
	end

	initial begin
		arst_n            = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_wr_data       = '0;
		item_ch.valid     = 1'b0;
		item_ch.value_in  = '0;
		item_ch.last_in   = 1'b0;
		result_ch.ready   = 1'b0;
		base_shadow       = word_t'(1);
		held_count        = 0;
		held_dropped      = 1'b0;
		mismatch_count    = 0;
		src_idle_pct      = 0;
		sink_stall_pct    = 0;
		hold_left         = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_extreme_values();
		test_ties_and_wrap();
		test_base_mid_run();
		test_capacity();
		test_backpressure();
		test_random_traffic();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (ranked_q.size() != 0) begin
			$error("%0d expected results never arrived", ranked_q.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule : tb

@@ filelist.f @@
rtl/isort_pkg.sv
rtl/isort_in_if.sv
rtl/isort_out_if.sv
rtl/isort_ram.sv
rtl/isort_ctrl.sv
rtl/isort_dp.sv
rtl/integer_sort_with_index.sv
tb/sv/tb.sv
